// File: rtl/core/dfr_pkg.sv
`timescale 1ns / 1ps

package dfr_pkg;

  localparam logic [7:0]  DLE_BYTE     = 8'h10;
  localparam logic [7:0]  STX_BYTE     = 8'h02;
  localparam logic [7:0]  ETX_BYTE     = 8'h03;
  localparam logic [7:0]  ACK_CODE     = 8'hAA;
  localparam logic [7:0]  NACK_CODE    = 8'h55;
  localparam logic [7:0]  CMD_LED_ON   = 8'h01;
  localparam logic [7:0]  CMD_LED_OFF  = 8'h02;
  localparam logic [15:0] ARC_POLY_REF = 16'hA001;
  localparam int          REPLY_MAX    = 10;

  typedef enum logic [2:0] {
    ST_SHORT     = 3'd0,
    ST_CRC_ERR   = 3'd1,
    ST_LED_ON    = 3'd2,
    ST_LED_OFF   = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_NOT_ADDR  = 3'd5
  } frame_status_t;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    mask;
    logic [7:0]    cmd;
    logic          led;
  } frame_rec_t;

  typedef struct packed {
    logic [REPLY_MAX-1:0][7:0] bytes;
    logic [3:0]                len;
  } reply_t;

  // one byte of CRC-16/ARC, reflected form
  function automatic logic [15:0] crc_step(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ ARC_POLY_REF;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic reply_t build_reply(logic [7:0] code);
    reply_t          r;
    logic [15:0]     rc;
    logic [2:0][7:0] body;
    logic [3:0]      n;
    r       = '0;
    rc      = crc_step(16'h0000, code);
    body[0] = code;
    body[1] = rc[15:8];
    body[2] = rc[7:0];
    n = 4'd0;
    r.bytes[n] = DLE_BYTE; n = n + 4'd1;
    r.bytes[n] = STX_BYTE; n = n + 4'd1;
    for (int i = 0; i < 3; i++) begin
      if (body[i] == DLE_BYTE) begin
        r.bytes[n] = DLE_BYTE; n = n + 4'd1;
      end
      r.bytes[n] = body[i]; n = n + 4'd1;
    end
    r.bytes[n] = DLE_BYTE; n = n + 4'd1;
    r.bytes[n] = ETX_BYTE; n = n + 4'd1;
    r.len = n;
    return r;
  endfunction

  localparam reply_t ACK_REPLY  = build_reply(ACK_CODE);
  localparam reply_t NACK_REPLY = build_reply(NACK_CODE);

endpackage

// File: rtl/core/dle_frame_receiver_with_reply_top.sv
`timescale 1ns / 1ps
// channel | dir | payload
// in_     | in  | tdata[7:0] rx_byte
// out_    | out | tdata: frame_status, dest_mask, command_code, led_level, tx_byte;
//         |     | tuser tx_valid, tlast last
// cfg_    | in  | wr_data[3:0] node_id
// One line byte a cycle while the queue has room; a closing DLE ETX queues a frame record
// (two-entry queue). The output side emits one transaction a cycle unless out_tready stalls:
// one for a frame without reply, seven for a reply frame. in_tready drops only while the queue is full.
// Reset: synchronous, rst_n low; node_id returns to 1, LED off, parser idle.

module dle_frame_receiver_with_reply_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] frame_status, [10:3] dest_mask, [18:11] command_code,
  // [19] led_level, [27:20] tx_byte, [31:28] zero
  output logic [31:0] out_tdata,
  output logic        out_tuser,  // [0] tx_valid
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import dfr_pkg::*;

  logic       q_full;
  logic       q_push;
  frame_rec_t q_rec;
  logic       q_pop;
  logic       head_valid;
  frame_rec_t head_rec;

  dfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_rec       (q_rec)
  );

  dfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  dfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/core/dfr_front.sv
`timescale 1ns / 1ps

module dfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  logic              q_full,
  output logic              q_push,
  output dfr_pkg::frame_rec_t q_rec
);
  import dfr_pkg::*;

  logic        in_frame_r, in_frame_nxt;
  logic        esc_r, esc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        led_r, led_nxt;
  logic [3:0]  node_r;
  logic [3:0][7:0] fb_r;
  logic        keep;
  logic [7:0]  keep_byte;
  logic        close;
  logic        acc;
  logic [3:0]  node_m1;
  logic        hit;
  frame_rec_t  rec;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign node_m1   = node_r - 4'd1;
  assign hit       = (node_r != 4'd0) && (node_r <= 4'd8) && fb_r[0][node_m1[2:0]];

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    keep         = 1'b0;
    keep_byte    = in_tdata;
    close        = 1'b0;
    if (acc) begin
      if (!in_frame_r) begin
        if (esc_r && in_tdata == STX_BYTE) begin
          in_frame_nxt = 1'b1;
          cnt_nxt      = 3'd0;
          crc_nxt      = 16'h0000;
          esc_nxt      = 1'b0;
        end else begin
          esc_nxt = (in_tdata == DLE_BYTE);
        end
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        if (in_tdata == ETX_BYTE) begin
          close        = 1'b1;
          in_frame_nxt = 1'b0;
          cnt_nxt      = 3'd0;
        end else if (in_tdata == DLE_BYTE) begin
          keep = 1'b1;
        end
      end else if (in_tdata == DLE_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        keep = 1'b1;
      end
      if (keep && cnt_r < 3'd4) begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r < 3'd2) begin
          crc_nxt = crc_step(crc_r, keep_byte);
        end
      end
    end
  end

  always_comb begin
    rec     = '0;
    led_nxt = led_r;
    if (cnt_r < 3'd4) begin
      rec.status = ST_SHORT;
    end else begin
      rec.mask = fb_r[0];
      rec.cmd  = fb_r[1];
      if ({fb_r[2], fb_r[3]} != crc_r) begin
        rec.status = ST_CRC_ERR;
      end else if (!hit) begin
        rec.status = ST_NOT_ADDR;
      end else if (fb_r[1] == CMD_LED_ON) begin
        rec.status = ST_LED_ON;
        led_nxt    = 1'b1;
      end else if (fb_r[1] == CMD_LED_OFF) begin
        rec.status = ST_LED_OFF;
        led_nxt    = 1'b0;
      end else begin
        rec.status = ST_UNKNOWN;
      end
    end
    rec.led = led_nxt;
  end

  assign q_push = close;
  assign q_rec  = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      cnt_r      <= 3'd0;
      crc_r      <= 16'h0000;
      led_r      <= 1'b0;
      node_r     <= 4'd1;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
      if (close) begin
        led_r <= led_nxt;
      end
      if (cfg_wr_en) begin
        node_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keep && cnt_r < 3'd4) begin
      fb_r[cnt_r[1:0]] <= (esc_r ? DLE_BYTE : in_tdata);
    end
  end

endmodule

// File: rtl/core/dfr_queue.sv
`timescale 1ns / 1ps

module dfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dfr_pkg::frame_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output dfr_pkg::frame_rec_t head_rec
);
  import dfr_pkg::*;

  frame_rec_t     mem_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_rec   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_rec;
    end
  end

endmodule

// File: rtl/core/dfr_back.sv
`timescale 1ns / 1ps

module dfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  dfr_pkg::frame_rec_t head_rec,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);
  import dfr_pkg::*;

  logic        vld_r;
  logic [31:0] data_r;
  logic        user_r;
  logic        last_r;
  logic [3:0]  idx_r, idx_nxt;
  logic        load;
  logic        has_reply;
  reply_t      rep;
  logic [3:0]  n_m1;
  logic        is_last;
  logic [7:0]  txb;

  assign load      = !vld_r || out_tready;
  assign has_reply = head_rec.status inside {ST_CRC_ERR, ST_LED_ON, ST_LED_OFF};
  assign rep       = (head_rec.status == ST_CRC_ERR) ? NACK_REPLY : ACK_REPLY;
  assign n_m1      = has_reply ? (rep.len - 4'd1) : 4'd0;
  assign is_last   = (idx_r == n_m1);
  assign txb       = has_reply ? rep.bytes[idx_r] : 8'h00;
  assign pop       = load && head_valid && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (load && head_valid) begin
      idx_nxt = is_last ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 4'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        vld_r <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      data_r <= {4'h0, txb, head_rec.led, head_rec.cmd, head_rec.mask, head_rec.status};
      user_r <= has_reply;
      last_r <= is_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule
